>>> rtl/sblur_pkg.sv
// sblur_pkg: shared types, register indexes and the 1-2-4-2-1 kernel
// used by the separable blur top level
// no dependencies
package sblur_pkg;

    typedef logic [23:0] pixel_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;

    localparam int STORED_ROWS = 4;
    localparam int FIFO_DEPTH  = 4;

    // 1-2-4-2-1 weighted sum per channel, divided by 16, truncated
    function automatic pixel_t mix5(input pixel_t a, input pixel_t b, input pixel_t c,
                                    input pixel_t d, input pixel_t e);
        pixel_t      res;
        logic [11:0] s;
        res = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            s = {4'd0, a[ch*8 +: 8]} + {3'd0, b[ch*8 +: 8], 1'b0}
              + {2'd0, c[ch*8 +: 8], 2'b0} + {3'd0, d[ch*8 +: 8], 1'b0}
              + {4'd0, e[ch*8 +: 8]};
            res[ch*8 +: 8] = s[11:4];
        end
        return res;
    endfunction

endpackage

>>> rtl/sblur_ram.sv
// sblur_ram: generic single-write, single-read synchronous ram
// registered read, read-first on a same-address write; no dependencies
module sblur_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/separable_blur_5tap_rgb.sv
// separable_blur_5tap_rgb: streaming 5x5 1-2-4-2-1 blur on bgr pixels
// uses sblur_pkg and four sblur_ram line stores
//
// usage
//   input channel (in_valid/in_ready): action 0 carries a source pixel in
//   raster order, action 1 asks for one pending output pixel after the
//   last pixel of the frame has arrived. output channel (out_valid/
//   out_ready) returns blurred pixels in raster order, frame_end on the
//   last pixel of the frame.
//   cfg_write/cfg_index/cfg_data set frame_width (0) and frame_height (1);
//   a write restarts the frame. write only while the block is idle.
// timing
//   one item per clock while in_ready is high. the item that completes an
//   output's neighborhood passes the line ram read, the vertical pass and
//   the horizontal pass into a 4-entry output queue. on frames of two rows
//   or fewer, or of three one-pixel rows, the first flush item holds
//   in_ready low while the horizontal window is primed from the line stores.
//   throughput is set by the one read port per line ram.
// reset and stall
//   reset clears positions and the output queue; registers go to 640x480.
//   line stores are not cleared. when out_ready is low the queue absorbs
//   items in flight and in_ready falls once it would overflow.
module separable_blur_5tap_rgb
    import sblur_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [11:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [7:0]           in_blue,
    input  logic [7:0]           in_green,
    input  logic [7:0]           in_red,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_blue,
    output logic [7:0]           out_green,
    output logic [7:0]           out_red,
    output logic                 frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [13:0] MAXW = 14'(MAX_WIDTH);
    localparam int QW = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic       push;
        logic       is_flush;
        logic       vert;
        logic [1:0] slot;
        logic       emit;
        logic       interior;
        logic       last;
        pixel_t     pix;
    } s1_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } s2_t;

    // configuration
    logic [11:0] frame_width_reg, frame_height_reg;
    logic [CW-1:0] wm1;
    logic [11:0]   hm1;

    // positions
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [11:0]   in_row_reg, in_row_next;
    logic [CW-1:0] f_col_reg, f_col_next;
    logic [11:0]   f_row_reg, f_row_next;
    logic [CW-1:0] o_col_reg, o_col_next;
    logic [11:0]   o_row_reg, o_row_next;
    logic [1:0]    gap_reg, gap_next;
    logic          busy_reg, busy_next;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;

    pixel_t vwin_reg [5];
    pixel_t cwin_reg [3];

    logic [QW:0]   q_cnt_reg;
    logic [QW-1:0] q_wr_reg, q_rd_reg;
    logic [24:0]   q_mem_reg [FIFO_DEPTH];

    logic          acc, in_done, pix_ok, flush_work, push, emit, is_last, restart;
    logic [CW-1:0] rd_addr;
    pixel_t        in_pix;
    pixel_t        rd_data [STORED_ROWS];
    pixel_t        center, temp, hout;
    logic          q_push, q_pop;
    logic [QW+1:0] inflight;

    // effective frame size
    always_comb
    begin
        if (frame_width_reg == 12'd0)
        begin
            wm1 = '0;
        end
        else if ({2'b00, frame_width_reg} > MAXW)
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(frame_width_reg - 12'd1);
        end
        hm1 = (frame_height_reg == 12'd0) ? 12'd0 : frame_height_reg - 12'd1;
    end

    assign in_pix   = {in_red, in_green, in_blue};
    assign inflight = {1'b0, q_cnt_reg} + {{(QW+1){1'b0}}, s1_reg.emit}
                    + {{(QW+1){1'b0}}, s2_reg.emit};
    assign in_ready = !busy_reg && (inflight < (QW+2)'(FIFO_DEPTH));
    assign acc      = in_valid && in_ready;
    assign in_done  = in_row_reg > hm1;
    assign pix_ok   = acc && !action && !in_done;
    // a flush pushes the source value two places ahead of its output
    assign flush_work = busy_reg || (acc && action && in_done && o_row_reg <= hm1);
    assign push     = (pix_ok && (|in_row_reg[11:1])) || flush_work;
    assign emit     = push && (gap_reg == 2'd2);
    assign is_last  = (o_col_reg == wm1) && (o_row_reg == hm1);
    assign restart  = (emit && is_last) || (acc && action && in_done && o_row_reg > hm1);
    assign rd_addr  = pix_ok ? in_col_reg : f_col_reg;

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        f_col_next  = f_col_reg;
        f_row_next  = f_row_reg;
        o_col_next  = o_col_reg;
        o_row_next  = o_row_reg;
        gap_next    = gap_reg;
        busy_next   = busy_reg;
        if (pix_ok)
        begin
            if (in_col_reg == wm1)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 12'd1;
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        if (push)
        begin
            if (f_col_reg == wm1)
            begin
                f_col_next = '0;
                f_row_next = f_row_reg + 12'd1;
            end
            else
            begin
                f_col_next = f_col_reg + CW'(1);
            end
            if (!emit)
            begin
                gap_next = gap_reg + 2'd1;
            end
        end
        if (flush_work)
        begin
            busy_next = !emit;
        end
        if (emit)
        begin
            if (o_col_reg == wm1)
            begin
                o_col_next = '0;
                o_row_next = o_row_reg + 12'd1;
            end
            else
            begin
                o_col_next = o_col_reg + CW'(1);
            end
        end
        if (restart || cfg_write)
        begin
            in_col_next = '0;
            in_row_next = '0;
            f_col_next  = '0;
            f_row_next  = '0;
            o_col_next  = '0;
            o_row_next  = '0;
            gap_next    = '0;
            busy_next   = 1'b0;
        end
    end

    always_comb
    begin
        s1_next.push     = push;
        s1_next.is_flush = flush_work;
        s1_next.vert     = pix_ok && (|in_row_reg[11:2]);
        s1_next.slot     = flush_work ? f_row_reg[1:0] : in_row_reg[1:0];
        s1_next.emit     = emit;
        s1_next.interior = (o_col_reg >= CW'(2))
                         && ({1'b0, o_col_reg} + (CW+1)'(2) <= {1'b0, wm1});
        s1_next.last     = is_last;
        s1_next.pix      = in_pix;
        s2_next.emit     = s1_reg.emit;
        s2_next.interior = s1_reg.interior;
        s2_next.last     = s1_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            f_col_reg        <= '0;
            f_row_reg        <= '0;
            o_col_reg        <= '0;
            o_row_reg        <= '0;
            gap_reg          <= '0;
            busy_reg         <= 1'b0;
            s1_reg           <= '0;
            s2_reg           <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == CFG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data;
            end
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            f_col_reg  <= f_col_next;
            f_row_reg  <= f_row_next;
            o_col_reg  <= o_col_next;
            o_row_reg  <= o_row_next;
            gap_reg    <= gap_next;
            busy_reg   <= busy_next;
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
        end
    end

    // one line store per row slot; the slot being written returns the row four back
    for (genvar i = 0; i < STORED_ROWS; i++)
    begin : g_line
        sblur_ram #(
            .DATA_W ($bits(pixel_t)),
            .DEPTH  (MAX_WIDTH)
        ) u_line (
            .clk     (clk),
            .wr_en   (pix_ok && in_row_reg[1:0] == 2'(i)),
            .wr_addr (in_col_reg),
            .wr_data (in_pix),
            .rd_addr (rd_addr),
            .rd_data (rd_data[i])
        );
    end

    // vertical pass
    always_comb
    begin
        center = s1_reg.is_flush ? rd_data[s1_reg.slot] : rd_data[s1_reg.slot + 2'd2];
        temp   = s1_reg.vert
               ? mix5(rd_data[s1_reg.slot], rd_data[s1_reg.slot + 2'd1], center,
                      rd_data[s1_reg.slot + 2'd3], s1_reg.pix)
               : center;
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.push)
        begin
            vwin_reg[0] <= temp;
            cwin_reg[0] <= center;
            for (int i = 1; i < 5; i++)
            begin
                vwin_reg[i] <= vwin_reg[i-1];
            end
            for (int i = 1; i < 3; i++)
            begin
                cwin_reg[i] <= cwin_reg[i-1];
            end
        end
    end

    // horizontal pass
    assign hout = s2_reg.interior
                ? mix5(vwin_reg[4], vwin_reg[3], vwin_reg[2], vwin_reg[1], vwin_reg[0])
                : cwin_reg[2];

    // output queue
    assign q_push = s2_reg.emit;
    assign q_pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
        end
        else
        begin
            if (q_push)
            begin
                q_wr_reg <= q_wr_reg + QW'(1);
            end
            if (q_pop)
            begin
                q_rd_reg <= q_rd_reg + QW'(1);
            end
            case ({q_push, q_pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + (QW+1)'(1);
                2'b01:   q_cnt_reg <= q_cnt_reg - (QW+1)'(1);
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[q_wr_reg] <= {s2_reg.last, hout};
        end
    end

    assign out_valid = q_cnt_reg != '0;
    assign {frame_end, out_red, out_green, out_blue} = q_mem_reg[q_rd_reg];

endmodule

>>> rtl/sblur_checker.sv
// sblur_checker: port-level checks for separable_blur_5tap_rgb
// bound to the top level at the end of this file; no dependencies
module sblur_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_blue,
    input logic [7:0] out_green,
    input logic [7:0] out_red,
    input logic       frame_end
);

    // items taken minus results given
    logic [31:0] owed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= '0;
        end
        else
        begin
            owed_reg <= owed_reg + {31'd0, in_valid && in_ready}
                      - {31'd0, out_valid && out_ready};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({out_blue, out_green, out_red, frame_end}))
        else $error("stalled result changed or dropped");

    // the queue is cleared asynchronously while reset is low
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result shown during reset");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> owed_reg != 32'd0)
        else $error("result without an accepted item");

    a_first_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind separable_blur_5tap_rgb sblur_checker u_sblur_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .frame_end (frame_end)
);
